FILE: sv/rrq_pkg.sv
package rrq_pkg;

  localparam int MAX_TASKS_DEF = 16;
  localparam int ID_W          = 4;
  localparam int SLICE_W       = 8;
  localparam int CNT_OUT_W     = 5;

  localparam logic [SLICE_W-1:0] SLICE_RST = 8'd5;

  typedef enum logic [1:0] {
    ACT_ENQ  = 2'd0,
    ACT_DEQ  = 2'd1,
    ACT_PICK = 2'd2,
    ACT_TICK = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ALREADY = 2'd1,
    ST_ABSENT  = 2'd2
  } status_t;

  typedef logic [ID_W-1:0] task_id_t;

  typedef struct packed {
    action_t  action;
    task_id_t task_id;
  } rrq_in_t;

  typedef struct packed {
    status_t              status;
    logic                 picked_valid;
    task_id_t             picked_id;
    logic                 slice_expired;
    logic [CNT_OUT_W-1:0] queue_count;
  } rrq_out_t;

  // Broadcast to every slot cell
  typedef struct packed {
    logic     enq;
    logic     deq;
    task_id_t id;
  } cell_ctrl_t;

  typedef struct packed {
    logic     go;
    action_t  action;
    task_id_t id;
    logic     full;
  } tt_req_t;

  typedef struct packed {
    logic id_ok;
    logic queued;
    logic resched;
  } tt_stat_t;

endpackage

FILE: sv/rrq_cell.sv
module rrq_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  rrq_pkg::cell_ctrl_t ctrl,
  input  logic                prev_valid,
  input  logic                found_in,
  input  rrq_pkg::task_id_t   next_id,
  input  logic                next_valid,
  output rrq_pkg::task_id_t   id,
  output logic                valid,
  output logic                found_out
);
  import rrq_pkg::*;

  task_id_t id_r;
  logic     valid_r;
  logic     match;
  logic     shift;
  logic     load;

  assign match     = valid_r && (id_r == ctrl.id);
  assign found_out = found_in | match;
  // at or behind the removed entry: take the neighbour's contents
  assign shift     = ctrl.deq && found_out;
  // first empty slot takes the new tail
  assign load      = ctrl.enq && !valid_r && prev_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (shift) begin
      valid_r <= next_valid;
    end else if (load) begin
      valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      id_r <= next_id;
    end else if (load) begin
      id_r <= ctrl.id;
    end
  end

  assign id    = id_r;
  assign valid = valid_r;

endmodule

FILE: sv/rrq_task_table.sv
module rrq_task_table #(
  parameter int MAX_TASKS = rrq_pkg::MAX_TASKS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  rrq_pkg::tt_req_t             req,
  input  logic [rrq_pkg::SLICE_W-1:0]  max_slice,
  output rrq_pkg::tt_stat_t            stat
);
  import rrq_pkg::*;

  localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

  logic [MAX_TASKS-1:0] queued_r;
  logic [SLICE_W-1:0]   slice_r [MAX_TASKS];

  logic [IDX_W-1:0]   idx;
  logic               id_ok;
  logic               cur_q;
  logic [SLICE_W-1:0] cur_slice;
  logic [SLICE_W-1:0] slice_dec;
  logic               enq_ok;
  logic               deq_ok;
  logic               tick_ok;

  assign idx       = IDX_W'(req.id);
  assign id_ok     = int'(req.id) < MAX_TASKS;
  assign cur_q     = id_ok ? queued_r[idx] : 1'b0;
  assign cur_slice = id_ok ? slice_r[idx] : '0;
  assign slice_dec = (cur_slice == '0) ? '0 : cur_slice - 1'b1;

  assign enq_ok  = req.go && (req.action == ACT_ENQ) && id_ok && !cur_q && !req.full;
  assign deq_ok  = req.go && (req.action == ACT_DEQ) && id_ok && cur_q;
  assign tick_ok = req.go && (req.action == ACT_TICK) && id_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      queued_r <= '0;
      for (int i = 0; i < MAX_TASKS; i++) begin
        slice_r[i] <= '0;
      end
    end else begin
      if (enq_ok) begin
        queued_r[idx] <= 1'b1;
        // reload an exhausted or oversized slice
        if ((cur_slice == '0) || (cur_slice > max_slice)) begin
          slice_r[idx] <= max_slice;
        end
      end
      if (deq_ok) begin
        queued_r[idx] <= 1'b0;
      end
      if (tick_ok) begin
        slice_r[idx] <= slice_dec;
      end
    end
  end

  assign stat.id_ok   = id_ok;
  assign stat.queued  = cur_q;
  assign stat.resched = id_ok && (slice_dec == '0);

endmodule

FILE: sv/round_robin_ready_queue_top.sv
// A command transferred at one clock edge gives its result with out_strobe high in the
// following cycle. One command is taken per cycle while busy is low, and the slot cell
// chain closes up on dequeue in one step.
// Reset (rst_n low, synchronous) empties the queue, clears all flags and slices and sets
// the maximum slice to 5; busy stays high through reset and the first cycle after it.
// The receiver cannot stall results.
module round_robin_ready_queue_top #(
  parameter int MAX_TASKS = rrq_pkg::MAX_TASKS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  rrq_pkg::rrq_in_t             in_item,
  output logic                         out_strobe,
  output rrq_pkg::rrq_out_t            out_item,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [rrq_pkg::SLICE_W-1:0]  cfg_data
);
  import rrq_pkg::*;

  localparam int CNT_W = $clog2(MAX_TASKS + 1);

  logic               ready_r;
  logic [SLICE_W-1:0] max_slice_r;
  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   count_nxt;
  logic               out_strobe_r;
  rrq_out_t           out_item_r;
  rrq_out_t           res;

  logic       accept;
  logic       full;
  logic       enq_ok;
  logic       deq_ok;
  tt_req_t    tt_req;
  tt_stat_t   tt_stat;
  cell_ctrl_t cell_ctrl;

  task_id_t               cell_id    [MAX_TASKS];
  logic [MAX_TASKS-1:0]   cell_valid;
  logic [MAX_TASKS:0]     found;

  assign accept    = start && ready_r;
  assign busy      = !ready_r;
  assign cfg_ready = ready_r;
  assign full      = (count_r == CNT_W'(MAX_TASKS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ready_r <= 1'b0;
    end else begin
      ready_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_slice_r <= SLICE_RST;
    end else if (cfg_valid && cfg_ready) begin
      max_slice_r <= cfg_data;
    end
  end

  assign tt_req.go     = accept;
  assign tt_req.action = in_item.action;
  assign tt_req.id     = in_item.task_id;
  assign tt_req.full   = full;

  rrq_task_table #(
    .MAX_TASKS (MAX_TASKS)
  ) u_task_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (tt_req),
    .max_slice (max_slice_r),
    .stat      (tt_stat)
  );

  assign enq_ok = accept && (in_item.action == ACT_ENQ) && tt_stat.id_ok &&
                  !tt_stat.queued && !full;
  assign deq_ok = accept && (in_item.action == ACT_DEQ) && tt_stat.id_ok && tt_stat.queued;

  assign cell_ctrl.enq = enq_ok;
  assign cell_ctrl.deq = deq_ok;
  assign cell_ctrl.id  = in_item.task_id;

  assign found[0] = 1'b0;

  for (genvar g = 0; g < MAX_TASKS; g++) begin : g_slot
    logic     prev_valid;
    task_id_t next_id;
    logic     next_valid;

    if (g == 0) begin : g_head
      assign prev_valid = 1'b1;
    end else begin : g_body
      assign prev_valid = cell_valid[g-1];
    end

    if (g == MAX_TASKS - 1) begin : g_tail
      assign next_id    = '0;
      assign next_valid = 1'b0;
    end else begin : g_link
      assign next_id    = cell_id[g+1];
      assign next_valid = cell_valid[g+1];
    end

    rrq_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (cell_ctrl),
      .prev_valid (prev_valid),
      .found_in   (found[g]),
      .next_id    (next_id),
      .next_valid (next_valid),
      .id         (cell_id[g]),
      .valid      (cell_valid[g]),
      .found_out  (found[g+1])
    );
  end

  always_comb begin
    count_nxt = count_r;
    if (enq_ok) begin
      count_nxt = count_r + 1'b1;
    end else if (deq_ok) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_comb begin
    res             = '0;
    res.status      = ST_OK;
    res.queue_count = CNT_OUT_W'(count_nxt);
    unique case (in_item.action)
      ACT_ENQ: begin
        if (!tt_stat.id_ok) begin
          res.status = ST_ABSENT;
        end else if (tt_stat.queued) begin
          res.status = ST_ALREADY;
        end
      end
      ACT_DEQ: begin
        if (!(tt_stat.id_ok && tt_stat.queued)) begin
          res.status = ST_ABSENT;
        end
      end
      ACT_PICK: begin
        if (cell_valid[0]) begin
          res.picked_valid = 1'b1;
          res.picked_id    = cell_id[0];
        end
      end
      ACT_TICK: begin
        res.slice_expired = tt_stat.resched;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_item_r <= res;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

endmodule

FILE: sv/rrq_checker.sv
module rrq_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         start,
  input logic                         busy,
  input rrq_pkg::rrq_in_t             in_item,
  input logic                         out_strobe,
  input rrq_pkg::rrq_out_t            out_item,
  input logic                         cfg_valid,
  input logic                         cfg_ready,
  input logic [rrq_pkg::SLICE_W-1:0]  cfg_data
);
  import rrq_pkg::*;

  // every transfer gives exactly one result, in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> out_strobe)
    else $error("no result after a command transfer");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |=> !out_strobe)
    else $error("result without a command transfer");

  a_pick_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.picked_valid) |->
      (out_item.status == ST_OK && out_item.queue_count != '0))
    else $error("pick reported a task from an empty queue");

  a_error_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.status != ST_OK) |->
      (!out_item.picked_valid && !out_item.slice_expired && out_item.picked_id == '0))
    else $error("error result carries pick or reschedule data");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && $past(out_strobe) && $past(rst_n)) |->
      (out_item.queue_count == $past(out_item.queue_count) ||
       out_item.queue_count == $past(out_item.queue_count) + 5'd1 ||
       out_item.queue_count == $past(out_item.queue_count) - 5'd1))
    else $error("queue count moved by more than one");

endmodule

bind round_robin_ready_queue_top rrq_checker u_rrq_checker (.*);
